// ===== hdl/pseg_pkg.sv =====
// Package: sizes, command codes and sequencer states for the polyline segment collision block.
`timescale 1ns / 1ps
`default_nettype none
package pseg_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int COORD_W    = 16;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int DIFF_W     = COORD_W + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int ACC_W      = PROD_W + 1;
	localparam int STEP_W     = 3;
	localparam int MUL_STEPS  = 6;
	localparam int SKIP_SEGS  = 3;

	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_CHECK  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOADC,
		ST_SEG,
		ST_MUL,
		ST_EVAL
	} state_t;

endpackage
`default_nettype wire

// ===== hdl/polyline_segment_collision.sv =====
// Top level: point store and iterative cross-product segment test.
//
// channel | signals                                   | role
// --------+-------------------------------------------+-----------------------------
// in      | in_valid, in_ready, cmd, ax, ay, bx, by   | append point or check segment
// out     | out_valid, out_ready, hit, store_full,    | one result per item
//         | point_count, last_x, last_y               |
//
// Append, and check with fewer than four points: the result is registered on acceptance and shown in the next cycle.
// Check: loads the first point (ST_LOADC), then tests at most count - 3 segments; each segment
// gets an operand step (ST_SEG), six products through the single shared 17x17 multiplier plus
// a final accumulate (ST_MUL), and a compare step (ST_EVAL). A hit ends the walk early.
// Reset clears the point count, last point and control; the store itself is not cleared.
// in_ready is low while a check runs and while an unaccepted result holds the output.
`timescale 1ns / 1ps
`default_nettype none
module polyline_segment_collision import pseg_pkg::*; (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire                       cmd,
	input  wire signed [COORD_W-1:0]  ax,
	input  wire signed [COORD_W-1:0]  ay,
	input  wire signed [COORD_W-1:0]  bx,
	input  wire signed [COORD_W-1:0]  by,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic                      hit,
	output logic                      store_full,
	output logic [CNT_W-1:0]          point_count,
	output logic signed [COORD_W-1:0] last_x,
	output logic signed [COORD_W-1:0] last_y
);

	logic [2*COORD_W-1:0] mem [MAX_POINTS];
	logic [2*COORD_W-1:0] rd_data_q;
	logic [ADDR_W-1:0]    rd_addr;

	state_t state_q, state_d;
	logic [CNT_W-1:0]          count_q;
	logic signed [COORD_W-1:0] last_x_q, last_y_q;
	logic                      out_valid_q, hit_q, full_q;
	logic [ADDR_W-1:0]         idx_q;
	logic [STEP_W-1:0]         step_q;

	logic signed [COORD_W-1:0] ax_q, ay_q, cx_q, cy_q, dx_q, dy_q;
	logic signed [DIFF_W-1:0]  rx_q, ry_q, sx_q, sy_q, qx_q, qy_q;
	logic signed [PROD_W-1:0]  p_q;
	logic signed [ACC_W-1:0]   den_q, tn_q, un_q;

	logic signed [DIFF_W-1:0]  op_a, op_b;
	logic signed [COORD_W-1:0] rd_x, rd_y;
	logic accept, is_check, can_walk, more_segs, seg_hit, res_set;
	logic signed [ACC_W-1:0]   p_ext, acc_sel, acc_new;

	assign accept    = in_valid && in_ready;
	assign is_check  = (cmd == CMD_CHECK);
	assign can_walk  = count_q > CNT_W'(SKIP_SEGS);
	assign more_segs = ({1'b0, idx_q} + CNT_W'(SKIP_SEGS + 1)) < count_q;
	assign rd_x      = rd_data_q[2*COORD_W-1:COORD_W];
	assign rd_y      = rd_data_q[COORD_W-1:0];
	assign res_set   = ((state_q == ST_IDLE) && accept && (!is_check || !can_walk))
		|| ((state_q == ST_EVAL) && (seg_hit || !more_segs));

	// segment test on the finished cross products
	always_comb begin
		seg_hit = 1'b0;
		if (den_q != '0) begin
			if (!den_q[ACC_W-1]) begin
				seg_hit = (tn_q >= 0) && (tn_q <= den_q) && (un_q >= 0) && (un_q <= den_q);
			end else begin
				seg_hit = (tn_q <= 0) && (tn_q >= den_q) && (un_q <= 0) && (un_q >= den_q);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_check && can_walk) state_d = ST_LOADC;
			end
			ST_LOADC: state_d = ST_SEG;
			ST_SEG:   state_d = ST_MUL;
			ST_MUL: begin
				if (step_q == STEP_W'(MUL_STEPS)) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (seg_hit || !more_segs) state_d = ST_IDLE;
				else state_d = ST_SEG;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		rd_addr  = '0;
		op_a     = rx_q;
		op_b     = sy_q;
		unique case (state_q)
			ST_IDLE:  in_ready = !out_valid_q || out_ready;
			ST_LOADC: rd_addr = idx_q + ADDR_W'(1);
			ST_SEG:   rd_addr = idx_q + ADDR_W'(1);
			ST_MUL: begin
				case (step_q)
					3'd0: begin op_a = rx_q; op_b = sy_q; end
					3'd1: begin op_a = ry_q; op_b = sx_q; end
					3'd2: begin op_a = qx_q; op_b = sy_q; end
					3'd3: begin op_a = qy_q; op_b = sx_q; end
					3'd4: begin op_a = qx_q; op_b = ry_q; end
					default: begin op_a = qy_q; op_b = rx_q; end
				endcase
			end
			ST_EVAL:  rd_addr = idx_q + ADDR_W'(2);
			default:  rd_addr = '0;
		endcase
	end

	// accumulate the product of the previous step: odd steps load, even steps subtract
	assign p_ext = ACC_W'(p_q);
	always_comb begin
		case (step_q)
			3'd2:    acc_sel = den_q;
			3'd4:    acc_sel = tn_q;
			default: acc_sel = un_q;
		endcase
		acc_new = step_q[0] ? p_ext : (acc_sel - p_ext);
	end

	always_ff @(posedge clk) begin
		if (accept && !is_check && (count_q < CNT_W'(MAX_POINTS))) begin
			mem[count_q[ADDR_W-1:0]] <= {ax, ay};
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			full_q      <= 1'b0;
			idx_q       <= '0;
			step_q      <= '0;
		end else begin
			state_q <= state_d;
			if (res_set) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q) inside
				ST_IDLE: begin
					idx_q  <= '0;
					step_q <= '0;
					if (accept) begin
						hit_q  <= 1'b0;
						full_q <= !is_check && (count_q >= CNT_W'(MAX_POINTS));
						if (!is_check && (count_q < CNT_W'(MAX_POINTS))) begin
							count_q  <= count_q + CNT_W'(1);
							last_x_q <= ax;
							last_y_q <= ay;
						end
					end
				end
				ST_LOADC, ST_SEG: step_q <= '0;
				ST_MUL: step_q <= step_q + STEP_W'(1);
				ST_EVAL: begin
					step_q <= '0;
					idx_q  <= idx_q + ADDR_W'(1);
					if (seg_hit || !more_segs) hit_q <= seg_hit;
				end
				default: step_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ax_q <= ax;
				ay_q <= ay;
				rx_q <= DIFF_W'(bx) - DIFF_W'(ax);
				ry_q <= DIFF_W'(by) - DIFF_W'(ay);
			end
			ST_LOADC: begin
				cx_q <= rd_x;
				cy_q <= rd_y;
			end
			ST_SEG: begin
				dx_q <= rd_x;
				dy_q <= rd_y;
				sx_q <= DIFF_W'(rd_x) - DIFF_W'(cx_q);
				sy_q <= DIFF_W'(rd_y) - DIFF_W'(cy_q);
				qx_q <= DIFF_W'(cx_q) - DIFF_W'(ax_q);
				qy_q <= DIFF_W'(cy_q) - DIFF_W'(ay_q);
			end
			ST_MUL: begin
				p_q <= op_a * op_b;
				case (step_q) inside
					3'd1, 3'd2: den_q <= acc_new;
					3'd3, 3'd4: tn_q  <= acc_new;
					3'd5, 3'd6: un_q  <= acc_new;
					default: ;
				endcase
			end
			ST_EVAL: begin
				cx_q <= dx_q;
				cy_q <= dy_q;
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign store_full  = full_q;
	assign point_count = count_q;
	assign last_x      = last_x_q;
	assign last_y      = last_y_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond store size");

	a_no_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !out_valid_q)
		else $error("result pending while a check runs");

	a_hit_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hit_q && full_q))
		else $error("hit and store_full both set");

	a_mul_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (step_q <= STEP_W'(MUL_STEPS)))
		else $error("multiply step out of range");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> (({1'b0, idx_q} + CNT_W'(SKIP_SEGS)) < count_q))
		else $error("segment index beyond eligible range");

endmodule
`default_nettype wire

// ===== verif/pseg_collision_checker.sv =====
// Checker for the polyline segment collision block: predicts every result and compares it.
`timescale 1ns / 1ps
module pseg_collision_checker import pseg_pkg::*; (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	input  wire                       in_ready,
	input  wire                       cmd,
	input  wire signed [COORD_W-1:0]  ax,
	input  wire signed [COORD_W-1:0]  ay,
	input  wire signed [COORD_W-1:0]  bx,
	input  wire signed [COORD_W-1:0]  by,
	input  wire                       out_valid,
	input  wire                       out_ready,
	input  wire                       hit,
	input  wire                       store_full,
	input  wire [CNT_W-1:0]           point_count,
	input  wire signed [COORD_W-1:0]  last_x,
	input  wire signed [COORD_W-1:0]  last_y,
	output int                        mismatches,
	output int                        outstanding
);

	typedef struct packed {
		logic                      hit;
		logic                      store_full;
		logic [CNT_W-1:0]          point_count;
		logic signed [COORD_W-1:0] last_x;
		logic signed [COORD_W-1:0] last_y;
	} poly_result_t;

	logic signed [COORD_W-1:0] poly_x [MAX_POINTS];
	logic signed [COORD_W-1:0] poly_y [MAX_POINTS];
	int                        poly_len;
	poly_result_t              awaited_results [$];
	int                        err_cnt;

	function automatic longint cross2(longint ux, uy, vx, vy);
		return ux * vy - uy * vx;
	endfunction

	function automatic bit segments_meet(longint pax, pay, pbx, pby, pcx, pcy, pdx, pdy);
		longint rx, ry, sx, sy, qx, qy, den, tn, un;
		rx = pbx - pax;
		ry = pby - pay;
		sx = pdx - pcx;
		sy = pdy - pcy;
		qx = pcx - pax;
		qy = pcy - pay;
		den = cross2(rx, ry, sx, sy);
		tn = cross2(qx, qy, sx, sy);
		un = cross2(qx, qy, rx, ry);
		if (den == 0)
			return 1'b0;
		if (den < 0) begin
			den = -den;
			tn = -tn;
			un = -un;
		end
		return (tn >= 0) && (tn <= den) && (un >= 0) && (un <= den);
	endfunction

	function automatic poly_result_t predict_result(logic c,
			logic signed [COORD_W-1:0] pax, pay, pbx, pby);
		poly_result_t r;
		r = '0;
		if (c == CMD_APPEND) begin
			if (poly_len < MAX_POINTS) begin
				poly_x[poly_len] = pax;
				poly_y[poly_len] = pay;
				poly_len++;
			end else begin
				r.store_full = 1'b1;
			end
		end else begin
			for (int i = 0; i + SKIP_SEGS < poly_len; i++) begin
				if (segments_meet(pax, pay, pbx, pby, poly_x[i], poly_y[i],
						poly_x[i+1], poly_y[i+1])) begin
					r.hit = 1'b1;
					break;
				end
			end
		end
		r.point_count = CNT_W'(poly_len);
		if (poly_len > 0) begin
			r.last_x = poly_x[poly_len-1];
			r.last_y = poly_y[poly_len-1];
		end
		return r;
	endfunction

	task automatic compare_field(string name, int want, int got);
		if (want != got) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		poly_result_t want;
		if (!arst_n) begin
			poly_len = 0;
			err_cnt = 0;
			awaited_results.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					err_cnt++;
					$display({"%0t: unexpected result, expected none actual ",
						"hit=%0b full=%0b count=%0d last=(%0d,%0d)"},
						$time, hit, store_full, point_count, last_x, last_y);
				end else begin
					want = awaited_results.pop_front();
					compare_field("hit", want.hit, hit);
					compare_field("store_full", want.store_full, store_full);
					compare_field("point_count", want.point_count, point_count);
					compare_field("last_x", want.last_x, last_x);
					compare_field("last_y", want.last_y, last_y);
				end
			end
			if (in_valid && in_ready)
				awaited_results.push_back(predict_result(cmd, ax, ay, bx, by));
			mismatches <= err_cnt;
			outstanding <= awaited_results.size();
		end
	end

endmodule

// ===== verif/tb_polyline_segment_collision.sv =====
// Testbench top: drives append and check transactions into the polyline collision block.
`timescale 1ns / 1ps
module tb_polyline_segment_collision;
	import pseg_pkg::*;

	localparam int     RANDOM_ITEMS = 560;
	localparam int     HOLD_CYCLES  = 300;
	localparam longint CYCLE_LIMIT  = 20_000_000;

	localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      cmd       = CMD_APPEND;
	logic                      out_ready = 1'b0;
	logic signed [COORD_W-1:0] ax        = '0;
	logic signed [COORD_W-1:0] ay        = '0;
	logic signed [COORD_W-1:0] bx        = '0;
	logic signed [COORD_W-1:0] by        = '0;
	wire                       in_ready;
	wire                       out_valid;
	wire                       hit;
	wire                       store_full;
	wire [CNT_W-1:0]           point_count;
	wire signed [COORD_W-1:0]  last_x;
	wire signed [COORD_W-1:0]  last_y;

	int                        mismatches;
	int                        outstanding;
	int                        results_seen = 0;
	int                        send_quiet   = 0;
	int                        recv_quiet   = 0;
	longint                    cycles       = 0;
	logic signed [COORD_W-1:0] trail_x [$];
	logic signed [COORD_W-1:0] trail_y [$];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	polyline_segment_collision DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .ax(ax), .ay(ay), .bx(bx), .by(by),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .store_full(store_full), .point_count(point_count),
		.last_x(last_x), .last_y(last_y)
	);

	pseg_collision_checker collision_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .ax(ax), .ay(ay), .bx(bx), .by(by),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .store_full(store_full), .point_count(point_count),
		.last_x(last_x), .last_y(last_y),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	function automatic int draw_gap(ref int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			quiet = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 19);
	endfunction

	function automatic logic signed [COORD_W-1:0] pick_coord();
		int v;
		v = $urandom_range(0, 127) - 64;
		case ($urandom_range(0, 7))
			0: return C_MIN;
			1: return C_MAX;
			2, 3: return COORD_W'($urandom);
			default: return COORD_W'(v);
		endcase
	endfunction

	task automatic pick_point(output logic signed [COORD_W-1:0] px, py);
		int k;
		if (trail_x.size() > 0 && $urandom_range(0, 3) == 0) begin
			k = $urandom_range(0, trail_x.size() - 1);
			px = trail_x[k];
			py = trail_y[k];
		end else begin
			px = pick_coord();
			py = pick_coord();
		end
	endtask

	task automatic send_item(logic c, logic signed [COORD_W-1:0] pax, pay, pbx, pby);
		int gap;
		gap = draw_gap(send_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		ax <= pax;
		ay <= pay;
		bx <= pbx;
		by <= pby;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (c == CMD_APPEND) begin
			trail_x.push_back(pax);
			trail_y.push_back(pay);
		end
	endtask

	task automatic append_point(logic signed [COORD_W-1:0] pax, pay);
		send_item(CMD_APPEND, pax, pay, COORD_W'($urandom), COORD_W'($urandom));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Receiver: random stalls per result, plus long hold-offs while the sender keeps going.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (results_seen == 30 || results_seen == 400)
				gap = HOLD_CYCLES;
			else
				gap = draw_gap(recv_quiet);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			results_seen++;
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic signed [COORD_W-1:0] pax, pay, pbx, pby;
		int k;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store, then fewer than four points
		send_item(CMD_CHECK, C_MAX, C_MIN, C_MIN, C_MAX);
		append_point(C_MIN, C_MIN);
		append_point(C_MAX, C_MAX);
		append_point(C_MIN, C_MAX);
		send_item(CMD_CHECK, C_MIN, C_MAX, C_MAX, C_MIN);
		append_point(C_MAX, C_MIN);
		// one eligible segment: the full diagonal
		send_item(CMD_CHECK, C_MIN, C_MAX, C_MAX, C_MIN);
		send_item(CMD_CHECK, C_MAX, C_MIN, C_MIN, C_MAX);
		send_item(CMD_CHECK, 16'sd0, 16'sd16, 16'sd16, 16'sd32);
		send_item(CMD_CHECK, -16'sd16, -16'sd16, 16'sd16, 16'sd16);
		send_item(CMD_CHECK, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_item(CMD_CHECK, 16'sd0, 16'sd0, 16'sd100, -16'sd100);
		send_item(CMD_CHECK, 16'sd100, 16'sd0, 16'sd200, -16'sd100);
		// horizontal segment along the top edge becomes eligible
		append_point(16'sd0, 16'sd0);
		send_item(CMD_CHECK, 16'sd0, 16'sd32700, 16'sd0, C_MAX);
		send_item(CMD_CHECK, 16'sd5, 16'sd32000, 16'sd5, 16'sd32766);
		send_item(CMD_CHECK, C_MIN, 16'sd0, C_MAX, 16'sd0);
		wait_drained();

		repeat (RANDOM_ITEMS) begin
			pick_point(pax, pay);
			if ($urandom_range(0, 99) < 35) begin
				append_point(pax, pay);
			end else begin
				case ($urandom_range(0, 9))
					0: begin
						pbx = pax;
						pby = pay;
					end
					1: begin
						if (trail_x.size() > 1) begin
							k = $urandom_range(0, trail_x.size() - 2);
							pbx = pax + trail_x[k+1] - trail_x[k];
							pby = pay + trail_y[k+1] - trail_y[k];
						end else begin
							pick_point(pbx, pby);
						end
					end
					default: pick_point(pbx, pby);
				endcase
				send_item(CMD_CHECK, pax, pay, pbx, pby);
			end
		end
		wait_drained();

		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
